### hdl/bdu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdu_pkg
// Shared types and constants for the Dynnikov coordinate braid update block.
// ----------------------------------------------------------------------------
package bdu_pkg;

  localparam int unsigned MaxPairsDef = 32;
  localparam logic [5:0]  StrandReset = 6'd34;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_APPLY = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_RNG = 2'd1,
    ST_SAT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_CALC,
    S_WR0,
    S_WR1,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    R_FIRST,
    R_LAST,
    R_MID
  } rule_e;

  typedef struct packed {
    logic    capture;
    logic    rd0;
    logic    rd1;
    logic    calc;
    logic    wr0;
    logic    wr1;
    logic    load;
    logic    out_set;
    status_e out_status;
    logic    out_read;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic idx_ok;
    logic gen_zero;
    logic gen_ok;
    logic two_pairs;
    logic sat;
  } stat_t;

  function automatic logic signed [34:0] posp(input logic signed [34:0] x);
    return x[34] ? '0 : x;
  endfunction

  function automatic logic signed [34:0] negp(input logic signed [34:0] x);
    return x[34] ? x : '0;
  endfunction

  function automatic logic ovf(input logic signed [34:0] x);
    return (x > 35'sd2147483647) || (x < -35'sd2147483648);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] x);
    if (x > 35'sd2147483647) return 32'h7fffffff;
    if (x < -35'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

### hdl/bdu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdu_ctrl
// Sequencer: loads or reads one pair, or reads up to two pairs, computes, writes back; presents result.
// ----------------------------------------------------------------------------
module bdu_ctrl
  import bdu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        cmd_o.out_set = 1'b1;
        state_d = S_OUT;
        case (stat_i.op)
          OP_LOAD: begin
            if (stat_i.idx_ok) begin
              cmd_o.load = 1'b1;
            end else begin
              cmd_o.out_status = ST_RNG;
            end
          end
          OP_READ: begin
            if (stat_i.idx_ok) begin
              cmd_o.out_set = 1'b0;
              cmd_o.rd0 = 1'b1;
              state_d = S_RD1;
            end else begin
              cmd_o.out_status = ST_RNG;
            end
          end
          OP_APPLY: begin
            if (!stat_i.gen_zero) begin
              if (!stat_i.gen_ok) begin
                cmd_o.out_status = ST_RNG;
              end else begin
                cmd_o.out_set = 1'b0;
                cmd_o.rd0 = 1'b1;
                state_d = S_RD1;
              end
            end
          end
          default: cmd_o.out_status = ST_RNG;
        endcase
      end
      S_RD1: begin
        if (stat_i.op == OP_READ) begin
          cmd_o.out_set  = 1'b1;
          cmd_o.out_read = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.rd1 = 1'b1;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = S_WR0;
      end
      S_WR0: begin
        cmd_o.wr0 = 1'b1;
        state_d = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr1 = stat_i.two_pairs;
        cmd_o.out_set = 1'b1;
        cmd_o.out_status = stat_i.sat ? ST_SAT : ST_OK;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/bdu_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdu_dpath
// Coordinate store, generator rule arithmetic and result registers.
// ----------------------------------------------------------------------------
module bdu_dpath
  import bdu_pkg::*;
#(
  parameter int unsigned MaxPairs = MaxPairsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [5:0]         strand_count_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [5:0]         pair_index_i,
  input  wire logic signed [31:0] load_a_i,
  input  wire logic signed [31:0] load_b_i,
  input  wire logic signed [6:0]  generator_i,
  input  wire cmd_t               cmd_i,
  output stat_t                   stat_o,
  output logic signed [31:0]      read_a_o,
  output logic signed [31:0]      read_b_o,
  output logic [1:0]              status_o
);

  localparam int unsigned AW = (MaxPairs > 1) ? $clog2(MaxPairs) : 1;
  localparam int unsigned NW = $clog2(MaxPairs + 3) + 1;

  logic [31:0] mem_a [MaxPairs];
  logic [31:0] mem_b [MaxPairs];
  logic [MaxPairs-1:0] vld_q;

  op_e               op_q;
  logic [5:0]        idx_q;
  logic signed [31:0] la_q, lb_q;
  logic signed [6:0]  gen_q;
  logic [NW-1:0]     n_q;

  logic [NW-1:0]  sc_ext, n_eff, mag;
  logic [AW-1:0]  addr0, addr1;
  rule_e          rule;
  logic           neg;

  logic signed [31:0] a0_q, b0_q, rda, rdb;
  logic signed [31:0] na0_q, nb0_q, na1_q, nb1_q;
  logic               sat_q;
  logic signed [31:0] ra_q, rb_q;
  logic [1:0]         st_q;

  logic signed [34:0] x0, y0, x1, y1, t, nb, na, ma0, mb0, ma1, mb1;

  always_comb begin
    sc_ext = NW'(strand_count_i);
    if (sc_ext < NW'(3)) n_eff = NW'(3);
    else if (sc_ext > NW'(MaxPairs + 2)) n_eff = NW'(MaxPairs + 2);
    else n_eff = sc_ext;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(opcode_i);
      idx_q <= pair_index_i;
      la_q  <= load_a_i;
      lb_q  <= load_b_i;
      gen_q <= generator_i;
      n_q   <= n_eff;
    end
  end

  assign neg = gen_q[6];
  assign mag = NW'(neg ? 7'(-gen_q) : gen_q);

  always_comb begin
    if (mag == NW'(1)) rule = R_FIRST;
    else if (mag == n_q - NW'(1)) rule = R_LAST;
    else rule = R_MID;
  end

  always_comb begin
    addr0 = '0;
    addr1 = '0;
    if (op_q != OP_APPLY) begin
      addr0 = AW'(idx_q - 6'd1);
    end else begin
      case (rule)
        R_FIRST: addr0 = '0;
        R_LAST:  addr0 = AW'(n_q - NW'(3));
        default: begin
          addr0 = AW'(mag - NW'(2));
          addr1 = AW'(mag - NW'(1));
        end
      endcase
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.idx_ok    = (idx_q != 6'd0) && (NW'(idx_q) <= n_q - NW'(2));
  assign stat_o.gen_zero  = (gen_q == '0);
  assign stat_o.gen_ok    = (mag <= n_q - NW'(1));
  assign stat_o.two_pairs = (rule == R_MID);
  assign stat_o.sat       = sat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_a[addr0] <= la_q;
      mem_b[addr0] <= lb_q;
    end else if (cmd_i.wr0) begin
      mem_a[addr0] <= na0_q;
      mem_b[addr0] <= nb0_q;
    end else if (cmd_i.wr1) begin
      mem_a[addr1] <= na1_q;
      mem_b[addr1] <= nb1_q;
    end
    if (cmd_i.rd0 || cmd_i.rd1) begin
      rda <= mem_a[cmd_i.rd0 ? addr0 : addr1];
      rdb <= mem_b[cmd_i.rd0 ? addr0 : addr1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.load || cmd_i.wr0) begin
      vld_q[addr0] <= 1'b1;
    end else if (cmd_i.wr1) begin
      vld_q[addr1] <= 1'b1;
    end
  end

  logic rd_vld_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd0 || cmd_i.rd1) begin
      rd_vld_q <= vld_q[cmd_i.rd0 ? addr0 : addr1];
    end
  end

  logic signed [31:0] rda_v, rdb_v;
  assign rda_v = rd_vld_q ? rda : '0;
  assign rdb_v = rd_vld_q ? rdb : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd1) begin
      a0_q <= rda_v;
      b0_q <= rdb_v;
    end
  end

  // rule arithmetic, pair 0 from a0/b0 and pair 1 (mid rule) from the fresh read
  always_comb begin
    x0 = 35'(a0_q);
    y0 = 35'(b0_q);
    x1 = 35'(rda_v);
    y1 = 35'(rdb_v);
    t = '0; nb = '0; na = '0;
    ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
    case (rule)
      R_FIRST: begin
        if (!neg) begin
          nb = x0 + posp(y0);
          na = -y0 + posp(nb);
        end else begin
          nb = -x0 + posp(y0);
          na = y0 - posp(nb);
        end
        ma0 = na; mb0 = nb;
      end
      R_LAST: begin
        if (!neg) begin
          nb = x0 + negp(y0);
          na = -y0 + negp(nb);
        end else begin
          nb = -x0 + negp(y0);
          na = y0 - negp(nb);
        end
        ma0 = na; mb0 = nb;
      end
      default: begin
        if (!neg) begin
          t   = x0 - x1 - posp(y1) + negp(y0);
          ma0 = x0 - posp(y0) - posp(posp(y1) + t);
          mb0 = y1 + negp(t);
          ma1 = x1 - negp(y1) - negp(negp(y0) - t);
          mb1 = y0 - negp(t);
        end else begin
          t   = x0 - x1 + posp(y1) - negp(y0);
          ma0 = x0 + posp(y0) + posp(posp(y1) - t);
          mb0 = y1 - posp(t);
          ma1 = x1 + negp(y1) + negp(negp(y0) + t);
          mb1 = y0 + posp(t);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      na0_q <= sat32(ma0);
      nb0_q <= sat32(mb0);
      na1_q <= sat32(ma1);
      nb1_q <= sat32(mb1);
      sat_q <= ovf(ma0) | ovf(mb0) |
               ((rule == R_MID) & (ovf(ma1) | ovf(mb1)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_set) begin
      ra_q <= cmd_i.out_read ? rda_v : '0;
      rb_q <= cmd_i.out_read ? rdb_v : '0;
      st_q <= cmd_i.out_status;
    end
  end

  assign read_a_o = ra_q;
  assign read_b_o = rb_q;
  assign status_o = st_q;

endmodule
`default_nettype wire

### hdl/braid_dynnikov_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// braid_dynnikov_update
// Dynnikov coordinate store with braid generator action and APB config.
// ----------------------------------------------------------------------------
// One item at a time; the next item is accepted only after the previous result
// has been taken. Load, zero-generator and out-of-range items pass states RD0
// and OUT, reads RD0, RD1 and OUT, generators RD0, RD1, CALC, WR0, WR1 and OUT.
// The coordinate memory is accessed one pair at a time: a generator reads it
// twice and writes back one pair, or two for a middle-rule generator. Register
// strand_count is at address 0.
module braid_dynnikov_update
  import bdu_pkg::*;
#(
  parameter int unsigned MaxPairs = MaxPairsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [5:0]         pair_index_i,
  input  wire logic signed [31:0] load_a_i,
  input  wire logic signed [31:0] load_b_i,
  input  wire logic signed [6:0]  generator_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      read_a_o,
  output logic signed [31:0]      read_b_o,
  output logic [1:0]              status_o
);

  logic [5:0] strand_q;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strand_q <= StrandReset;
    end else if (psel && penable && pwrite && !paddr) begin
      strand_q <= pwdata[5:0];
    end
  end

  assign prdata = paddr ? '0 : {26'd0, strand_q};

  bdu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bdu_dpath #(.MaxPairs(MaxPairs)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .strand_count_i(strand_q),
    .opcode_i      (opcode_i),
    .pair_index_i  (pair_index_i),
    .load_a_i      (load_a_i),
    .load_b_i      (load_b_i),
    .generator_i   (generator_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .read_a_o      (read_a_o),
    .read_b_o      (read_b_o),
    .status_o      (status_o)
  );

endmodule
`default_nettype wire
